### sv/ksv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the singleton value filter.
// Used by the controller, the datapath and the top level; depends on nothing.
package ksv_pkg;

	localparam int DEPTH = 64;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int VW    = 31;

	typedef enum logic [2:0] {
		S_LOAD,
		S_FETCH,
		S_HOLD,
		S_SCAN,
		S_PUSH,
		S_FINAL
	} state_t;

	typedef struct packed {
		logic wr_en;        // store the input value and count it
		logic clr_count;    // start a new sequence
		logic i_clr;
		logic i_inc;
		logic j_clr;
		logic rd_fetch;     // read the candidate entry
		logic scan_rd;      // read the next scan entry and advance j
		logic cand_ld;
		logic pend_ld;
		logic out_ld_pend;  // move the pending value out as a non-final result
		logic out_ld_final; // send the closing result of the run
	} ctrl_cmd_t;

	typedef struct packed {
		logic value_neg;
		logic count_zero;
		logic full_next;
		logic hit;
		logic last_cmp;
		logic i_last;
		logic j_done;
		logic out_free;
		logic pend_vld;
	} ctrl_sts_t;

endpackage

### sv/keep_singleton_values_filter_core.sv
`timescale 1ns / 1ps
// Top level of the singleton value filter: controller plus datapath.
// Depends on ksv_pkg, ksv_ctrl and ksv_dp.
//
// Non-negative values load one per cycle into a 64-entry store. A negative value, or the
// value that fills the store, ends the sequence; the block then stalls its input and walks
// the store with its single RAM read port: for each of the n stored values it reads the
// value, then scans the store until a duplicate is found or all n entries are compared,
// and a stalled output can hold the walk. Each value that occurs exactly once is sent out
// in its original order, the final one with last set; a sequence without such a value
// gives one result with empty_res and last set. No clearing pass is needed after reset.
module keep_singleton_values_filter_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [31:0]     value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [ksv_pkg::VW-1:0] unique_value,
	output logic                   last,
	output logic                   empty_res
);

	ksv_pkg::ctrl_cmd_t cmd;
	ksv_pkg::ctrl_sts_t sts;

	ksv_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.sts     (sts),
		.in_stall(in_stall),
		.cmd     (cmd)
	);

	ksv_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.cmd         (cmd),
		.sts         (sts),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.unique_value(unique_value),
		.last        (last),
		.empty_res   (empty_res)
	);

	// The empty marker only ever rides on the closing transfer, with a zero value.
	a_empty_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |-> last && (unique_value == '0))
		else $error("empty result without last or with a value");

	// Values are stored only on an accepted non-negative input.
	a_store_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> in_valid && !in_stall && !value[31])
		else $error("store write without an accepted value");

	// A non-final result is only pushed from a held pending value into a free register.
	a_push_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld_pend |-> sts.pend_vld && sts.out_free)
		else $error("result pushed without a pending value or free output");

	// Input is never taken during the compare walk.
	a_no_accept_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_rd || cmd.rd_fetch |-> in_stall)
		else $error("input accepted during the compare walk");

endmodule

### sv/ksv_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module ksv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/ksv_dp.sv
`timescale 1ns / 1ps
// Datapath: value store, sequence counters, compare stage and result registers.
// Depends on ksv_pkg and ksv_ram.
module ksv_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic signed [31:0]    value,
	input  ksv_pkg::ctrl_cmd_t    cmd,
	output ksv_pkg::ctrl_sts_t    sts,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [ksv_pkg::VW-1:0] unique_value,
	output logic                  last,
	output logic                  empty_res
);

	logic [ksv_pkg::CW-1:0] count_q;
	logic [ksv_pkg::CW-1:0] i_q;
	logic [ksv_pkg::CW-1:0] j_q;
	logic [ksv_pkg::VW-1:0] cand_q;
	logic [ksv_pkg::VW-1:0] pend_q;
	logic                   pend_vld_q;
	logic                   scan_vld_s1;
	logic [ksv_pkg::AW-1:0] rd_idx_s1;
	logic                   out_vld_q;
	logic [ksv_pkg::VW-1:0] out_val_q;
	logic                   out_last_q;
	logic                   out_empty_q;
	logic [ksv_pkg::VW-1:0] rdata;
	logic                   re;
	logic [ksv_pkg::AW-1:0] raddr;
	logic                   out_free;

	assign re    = cmd.rd_fetch | cmd.scan_rd;
	assign raddr = cmd.scan_rd ? j_q[ksv_pkg::AW-1:0] : i_q[ksv_pkg::AW-1:0];

	ksv_ram #(
		.WIDTH(ksv_pkg::VW),
		.DEPTH(ksv_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(count_q[ksv_pkg::AW-1:0]),
		.wdata(value[ksv_pkg::VW-1:0]),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			pend_vld_q  <= 1'b0;
			scan_vld_s1 <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cmd.clr_count) begin
				count_q <= '0;
			end else if (cmd.wr_en) begin
				count_q <= count_q + ksv_pkg::CW'(1);
			end
			if (cmd.i_clr) begin
				i_q <= '0;
			end else if (cmd.i_inc) begin
				i_q <= i_q + ksv_pkg::CW'(1);
			end
			if (cmd.j_clr) begin
				j_q <= '0;
			end else if (cmd.scan_rd) begin
				j_q <= j_q + ksv_pkg::CW'(1);
			end
			if (cmd.out_ld_final) begin
				pend_vld_q <= 1'b0;
			end else if (cmd.pend_ld) begin
				pend_vld_q <= 1'b1;
			end
			scan_vld_s1 <= cmd.scan_rd;
			if (cmd.out_ld_pend || cmd.out_ld_final) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= j_q[ksv_pkg::AW-1:0];
		if (cmd.cand_ld) begin
			cand_q <= rdata;
		end
		if (cmd.pend_ld) begin
			pend_q <= cand_q;
		end
		if (cmd.out_ld_pend) begin
			out_val_q   <= pend_q;
			out_last_q  <= 1'b0;
			out_empty_q <= 1'b0;
		end else if (cmd.out_ld_final) begin
			out_val_q   <= pend_vld_q ? pend_q : '0;
			out_last_q  <= 1'b1;
			out_empty_q <= ~pend_vld_q;
		end
	end

	assign out_free = ~out_vld_q | ~out_stall;

	always_comb begin
		sts.value_neg  = value[31];
		sts.count_zero = (count_q == '0);
		sts.full_next  = (count_q == ksv_pkg::CW'(ksv_pkg::DEPTH - 1));
		// A match at any other position disqualifies the candidate.
		sts.hit        = scan_vld_s1 && (rd_idx_s1 != i_q[ksv_pkg::AW-1:0])
			&& (rdata == cand_q);
		sts.last_cmp   = scan_vld_s1
			&& ({1'b0, rd_idx_s1} == ksv_pkg::CW'(count_q - ksv_pkg::CW'(1)));
		sts.i_last     = ((i_q + ksv_pkg::CW'(1)) == count_q);
		sts.j_done     = (j_q == count_q);
		sts.out_free   = out_free;
		sts.pend_vld   = pend_vld_q;
	end

	assign out_valid    = out_vld_q;
	assign unique_value = out_val_q;
	assign last         = out_last_q;
	assign empty_res    = out_empty_q;

endmodule

### sv/ksv_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences loading, the pairwise compare walk and the result run.
// Depends on ksv_pkg.
module ksv_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  ksv_pkg::ctrl_sts_t sts,
	output logic               in_stall,
	output ksv_pkg::ctrl_cmd_t cmd
);

	ksv_pkg::state_t state_q;
	ksv_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ksv_pkg::S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != ksv_pkg::S_LOAD);
		unique case (state_q)
			ksv_pkg::S_LOAD: begin
				if (in_valid) begin
					if (sts.value_neg) begin
						cmd.i_clr = 1'b1;
						state_d   = sts.count_zero ? ksv_pkg::S_FINAL : ksv_pkg::S_FETCH;
					end else begin
						cmd.wr_en = 1'b1;
						if (sts.full_next) begin
							cmd.i_clr = 1'b1;
							state_d   = ksv_pkg::S_FETCH;
						end
					end
				end
			end
			ksv_pkg::S_FETCH: begin
				cmd.rd_fetch = 1'b1;
				cmd.j_clr    = 1'b1;
				state_d      = ksv_pkg::S_HOLD;
			end
			ksv_pkg::S_HOLD: begin
				cmd.cand_ld = 1'b1;
				cmd.scan_rd = 1'b1;
				state_d     = ksv_pkg::S_SCAN;
			end
			ksv_pkg::S_SCAN: begin
				// Stop issuing reads once a duplicate shows up so none is left in flight.
				cmd.scan_rd = ~sts.hit & ~sts.j_done;
				if (sts.hit) begin
					cmd.i_inc = 1'b1;
					state_d   = sts.i_last ? ksv_pkg::S_FINAL : ksv_pkg::S_FETCH;
				end else if (sts.last_cmp) begin
					state_d = ksv_pkg::S_PUSH;
				end
			end
			ksv_pkg::S_PUSH: begin
				// The newest unique value waits in the pending register until we
				// know whether it is the final one of the run.
				if (!sts.pend_vld || sts.out_free) begin
					cmd.out_ld_pend = sts.pend_vld;
					cmd.pend_ld     = 1'b1;
					cmd.i_inc       = 1'b1;
					state_d         = sts.i_last ? ksv_pkg::S_FINAL : ksv_pkg::S_FETCH;
				end
			end
			ksv_pkg::S_FINAL: begin
				if (sts.out_free) begin
					cmd.out_ld_final = 1'b1;
					cmd.clr_count    = 1'b1;
					state_d          = ksv_pkg::S_LOAD;
				end
			end
			default: begin
				state_d = ksv_pkg::S_LOAD;
			end
		endcase
	end

endmodule
